[rtl/llmg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llmg_pkg: shared types and constants of the Lehmer LCG generator
// Widths, command and register codes, reset values, divider control and status structs.
// ----------------------------------------------------------------------------
package llmg_pkg;

  localparam int WORD_W    = 32;
  localparam int MOD_W     = 33;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int CFG_IDX_W = 8;
  localparam int CNT_W     = $clog2(PROD_W);

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MULT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MOD  = CFG_IDX_W'(1);

  localparam logic [WORD_W-1:0] MULT_RST = WORD_W'(16807);
  localparam logic [MOD_W-1:0]  MOD_RST  = MOD_W'(2147483647);

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

[rtl/llmg_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llmg_in_if: command channel
// One beat carries a step or seed command with its seed value.
// ----------------------------------------------------------------------------
interface llmg_in_if
  import llmg_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [WORD_W-1:0] seed_value;

  modport source (output valid, output cmd, output seed_value, input ready);
  modport sink   (input valid, input cmd, input seed_value, output ready);
endinterface
`default_nettype wire

[rtl/llmg_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llmg_out_if: result channel
// One beat carries one generated word.
// ----------------------------------------------------------------------------
interface llmg_out_if
  import llmg_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface
`default_nettype wire

[rtl/llmg_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llmg_cfg_if: register write channel
// One beat writes data to the register selected by index.
// ----------------------------------------------------------------------------
interface llmg_cfg_if
  import llmg_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MOD_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/llmg_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llmg_div: iterative restoring remainder unit
// Reduces a 64-bit dividend by a nonzero 33-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module llmg_div
  import llmg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire div_ctl_t          ctl,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [MOD_W-1:0]  divisor,
  output div_sts_t               sts,
  output logic [MOD_W-1:0]       rem
);

  logic [PROD_W-1:0] dvd_r;
  logic [MOD_W-1:0]  dsr_r;
  logic [MOD_W-1:0]  rem_r;
  logic [MOD_W-1:0]  rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [MOD_W:0]    trial;
  logic [MOD_W+1:0]  diff;

  always_comb begin
    trial   = {rem_r, dvd_r[PROD_W-1]};
    diff    = {1'b0, trial} - {2'b00, dsr_r};
    rem_nxt = diff[MOD_W+1] ? trial[MOD_W-1:0] : diff[MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[PROD_W-2:0], 1'b0};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign rem      = rem_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r && cnt_r == '0)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while busy");
  a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < dsr_r)
    else $error("partial remainder not below divisor");

endmodule
`default_nettype wire

[rtl/lehmer_lcg_modulo_generator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lehmer_lcg_modulo_generator_top: Lehmer multiplicative LCG
// A step beat multiplies the 32-bit state by the multiplier register into a
// registered product, then a restoring remainder unit reduces the 64-bit
// product by the modulus register at one bit per cycle. A modulus of zero
// skips the remainder loop and keeps the low product word. A seed beat loads
// the state and gives no result. The block takes no command while a step is
// in flight; a finished result waits in a pending register until the output
// register is free, and no command is taken while it waits.
// Registers: index 0 multiplier (reset 16807), index 1 modulus
// (reset 2^31 - 1); write them only while idle. Other indexes are ignored.
// ----------------------------------------------------------------------------
module lehmer_lcg_modulo_generator_top
  import llmg_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  llmg_in_if.sink     in_ch,
  llmg_out_if.source  out_ch,
  llmg_cfg_if.sink    cfg_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV
  } state_t;

  state_t            state_r;
  logic [WORD_W-1:0] cur_r;
  logic [WORD_W-1:0] mult_r;
  logic [MOD_W-1:0]  mod_r;
  logic [PROD_W-1:0] prod_r;
  logic [WORD_W-1:0] res_r;
  logic              res_pend_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              in_beat;
  logic              out_free;
  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [MOD_W-1:0]  div_rem;

  assign in_ch.ready   = (state_r == ST_IDLE) && !res_pend_r;
  assign in_beat       = in_ch.valid && in_ch.ready;
  assign out_free      = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign div_ctl.start = (state_r == ST_START) && (mod_r != '0);

  llmg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (prod_r),
    .divisor  (mod_r),
    .sts      (div_sts),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= MULT_RST;
      mod_r  <= MOD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MULT: mult_r <= cfg_ch.data[WORD_W-1:0];
        REG_MOD:  mod_r  <= cfg_ch.data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_pend_r && out_free) begin
        out_valid_r <= 1'b1;
        out_word_r  <= res_r;
        res_pend_r  <= 1'b0;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            if (in_ch.cmd == CMD_SEED) cur_r <= in_ch.seed_value;
            else state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= PROD_W'(cur_r) * PROD_W'(mult_r);
          state_r <= ST_START;
        end
        ST_START: begin
          if (mod_r == '0) begin
            cur_r      <= prod_r[WORD_W-1:0];
            res_r      <= prod_r[WORD_W-1:0];
            res_pend_r <= 1'b1;
            state_r    <= ST_IDLE;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_sts.done) begin
            cur_r      <= div_rem[WORD_W-1:0];
            res_r      <= div_rem[WORD_W-1:0];
            res_pend_r <= 1'b1;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_word_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_DIV)
    else $error("remainder done outside divide state");
  a_step_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_ch.cmd == CMD_STEP |=> state_r == ST_MUL)
    else $error("step beat did not start multiply");
  a_seed_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_ch.cmd == CMD_SEED |=> cur_r == $past(in_ch.seed_value))
    else $error("seed not loaded");
  a_div_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> state_r == ST_DIV)
    else $error("remainder unit busy outside divide state");

endmodule
`default_nettype wire

[tb/tb_lehmer_lcg_modulo_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lehmer_lcg_modulo_generator_top: self-checking bench for the Lehmer LCG
// Walks a directed table (zero state, seeds, multiplier and modulus extremes,
// zero modulus, modulus above 2^32, ignored register writes), then runs
// random phases under several register settings. A generator model predicts
// words the table does not fix; both sides idle at random but in late phases.
// ----------------------------------------------------------------------------
module tb_lehmer_lcg_modulo_generator_top;
  import llmg_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RST_CYCLES     = 11;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 80;
  localparam int STALL_LIMIT    = 3000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 83;
  localparam int SEED_PCT       = 15;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(255);

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic                 cmd;
    logic [CFG_IDX_W-1:0] idx;
    logic [MOD_W-1:0]     data;
    logic                 has_word;
    logic [WORD_W-1:0]    word;
  } dir_row_t;

  localparam int DIR_ROWS_N = 32;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_5A5A_A5A5, 1'b1, 32'd0},
    '{ROW_ITEM, CMD_SEED, REG_MULT, 33'h0_0000_0001, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_FFFF_FFFF, 1'b1, 32'd16807},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_0000_0000, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_SEED, REG_MULT, 33'h0_FFFF_FFFF, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_1234_5678, 1'b1, 32'd16807},
    '{ROW_ITEM, CMD_SEED, REG_MULT, 33'h0_7FFF_FFFF, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_8000_0000, 1'b1, 32'd0},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_0000_0000, 1'b1, 32'd0},
    '{ROW_CFG,  CMD_STEP, REG_MULT, 33'h1_FFFF_FFFF, 1'b0, 32'd0},
    '{ROW_CFG,  CMD_STEP, REG_MOD,  33'h0_0000_0000, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_SEED, REG_MULT, 33'h0_FFFF_FFFF, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_0000_0000, 1'b1, 32'd1},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_C3C3_3C3C, 1'b0, 32'd0},
    '{ROW_CFG,  CMD_STEP, REG_UNUSED_LO, 33'h1_2345_6789, 1'b0, 32'd0},
    '{ROW_CFG,  CMD_STEP, REG_MOD,  33'h1_FFFF_FFFF, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_SEED, REG_MULT, 33'h0_FFFF_FFFF, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_0000_0000, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_FFFF_FFFF, 1'b0, 32'd0},
    '{ROW_CFG,  CMD_STEP, REG_MOD,  33'h1_0000_0000, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_SEED, REG_MULT, 33'h0_DEAD_BEEF, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_0000_0000, 1'b0, 32'd0},
    '{ROW_CFG,  CMD_STEP, REG_MULT, 33'h0_0000_0000, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_FFFF_FFFF, 1'b1, 32'd0},
    '{ROW_CFG,  CMD_STEP, REG_MULT, {1'b0, MULT_RST}, 1'b0, 32'd0},
    '{ROW_CFG,  CMD_STEP, REG_MOD,  33'h0_0000_0001, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_SEED, REG_MULT, 33'h0_0000_3039, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_0000_0000, 1'b1, 32'd0},
    '{ROW_CFG,  CMD_STEP, REG_UNUSED_HI, 33'h1_5555_5555, 1'b0, 32'd0},
    '{ROW_CFG,  CMD_STEP, REG_MOD,  MOD_RST, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_SEED, REG_MULT, 33'h0_0000_002A, 1'b0, 32'd0},
    '{ROW_ITEM, CMD_STEP, REG_MULT, 33'h0_0000_0000, 1'b0, 32'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  llmg_in_if  in_ch ();
  llmg_out_if out_ch ();
  llmg_cfg_if cfg_ch ();

  lehmer_lcg_modulo_generator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // generator model
  logic [WORD_W-1:0] lcg_mult;
  logic [MOD_W-1:0]  lcg_mod;
  logic [WORD_W-1:0] lcg_state;
  logic [WORD_W-1:0] words_q [$];
  logic [WORD_W-1:0] expected_word;

  int err_count      = 0;
  int stall_cycles   = 0;
  int send_idle_pct  = 29;
  int recv_stall_pct = 49;

  function automatic logic [WORD_W-1:0] lcg_advance(input logic [WORD_W-1:0] s);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rem;
    prod = {32'd0, s} * {32'd0, lcg_mult};
    if (lcg_mod != '0) begin
      rem = prod % {31'd0, lcg_mod};
    end else begin
      rem = prod;
    end
    return rem[WORD_W-1:0];
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [MOD_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_MULT: lcg_mult = data[WORD_W-1:0];
      REG_MOD:  lcg_mod  = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_cmd(input logic cmd, input logic [WORD_W-1:0] seed,
                          input logic has_word, input logic [WORD_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.seed_value <= seed;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_SEED) begin
      lcg_state = seed;
    end else begin
      lcg_state = lcg_advance(lcg_state);
      words_q.push_back(has_word ? word : lcg_state);
    end
    @(negedge clk);
  endtask

  // waits until every expected word has been seen, then lets the block settle
  task automatic drain_idle();
    in_ch.valid <= 1'b0;
    while (words_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int phase);
    logic [WORD_W-1:0] mult;
    logic [MOD_W-1:0]  modv;
    logic [WORD_W-1:0] seed;
    drain_idle();
    case (phase)
      0: begin mult = MULT_RST;          modv = MOD_RST; end
      1: begin mult = 32'd48271;         modv = MOD_RST; end
      2: begin mult = $urandom;          modv = {1'b0, 32'($urandom)} + 33'd1; end
      3: begin mult = 32'hFFFF_FFFF;     modv = '0; end
      4: begin mult = $urandom;          modv = 33'h1_FFFF_FFFF; end
      5: begin mult = 32'd1;             modv = {1'b0, 32'($urandom)} + 33'd1; end
      6: begin mult = $urandom;          modv = {1'b1, 32'($urandom)}; end
      7: begin mult = 32'hFFFF_FFFF;     modv = 33'h1_0000_0000; end
      8: begin mult = $urandom;          modv = 33'($urandom_range(1, 1000)); end
      default: begin mult = $urandom;    modv = {1'($urandom_range(0, 1)), 32'($urandom)}; end
    endcase
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(CFG_IDX_W'($urandom_range(2, 255)), {1'($urandom_range(0, 1)), 32'($urandom)});
    end
    cfg_write(REG_MULT, {1'($urandom_range(0, 1)), mult});
    cfg_write(REG_MOD, modv);
    cfg_ch.valid <= 1'b0;
    if (phase < 3) begin
      send_idle_pct = 29;  recv_stall_pct = 49;
    end else if (phase < 6) begin
      send_idle_pct = 49;  recv_stall_pct = 29;
    end else begin
      send_idle_pct = 0;   recv_stall_pct = 0;
    end
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < SEED_PCT) begin
        case ($urandom_range(0, 5))
          0:       seed = '0;
          1:       seed = '1;
          2:       seed = lcg_mod[WORD_W-1:0];
          default: seed = $urandom;
        endcase
        send_cmd(CMD_SEED, seed, 1'b0, '0);
      end else begin
        send_cmd(CMD_STEP, $urandom, 1'b0, '0);
      end
    end
  endtask

  // stimulus
  initial begin
    dir_row_t row;
    logic     dirty;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_STEP;
    in_ch.seed_value = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_MULT;
    cfg_ch.data      = '0;
    lcg_mult         = MULT_RST;
    lcg_mod          = MOD_RST;
    lcg_state        = '0;
    dirty            = 1'b0;
    repeat (RST_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) begin
        if (dirty) begin
          drain_idle();
          dirty = 1'b0;
        end
        cfg_write(row.idx, row.data);
      end else begin
        cfg_ch.valid <= 1'b0;
        send_cmd(row.cmd, row.data[WORD_W-1:0], row.has_word, row.word);
        dirty = 1'b1;
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) run_phase(p);

    in_ch.valid <= 1'b0;
    while (words_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // output backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // output beat checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (words_q.size() == 0) begin
        report_error($sformatf("unexpected beat 0x%08h", out_ch.random_word));
      end else begin
        expected_word = words_q.pop_front();
        if (out_ch.random_word !== expected_word) begin
          report_error($sformatf("random_word got 0x%08h, expected 0x%08h",
                                 out_ch.random_word, expected_word));
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR @%0t: no beat for %0d cycles", $realtime, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
